/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define MOG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, held off while reset is high.
`define MOG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/core/mog_pkg.sv */
// Package: types, constants and control structs of the outlier gate.
`default_nettype none
package mog_pkg;

  // Default depth of the match store.
  localparam int MAX_MATCHES_DEF = 64;

  // Field widths.
  localparam int DISP_W  = 20;
  localparam int KEY_W   = 21;
  localparam int GAIN_W  = 12;
  localparam int INDEX_W = 6;
  localparam int BIT_W   = 5;

  // Top bit of a selection key.
  localparam logic [BIT_W-1:0] KEY_TOP_BIT = BIT_W'(KEY_W - 1);

  // 1.4826 in Q12, 3.0 px in Q8 and the gate ceiling.
  localparam logic [12:0]      MAD_COEF_Q12 = 13'd6073;
  localparam logic [KEY_W-1:0] MIN_GATE_Q8  = 21'd768;
  localparam logic [KEY_W-1:0] GATE_MAX     = 21'h1FFFFF;
  localparam logic [GAIN_W-1:0] GAIN_RESET  = 12'd768;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_DECIDE,
    S_COMBINE,
    S_GMUL,
    S_GSET,
    S_EMIT_RD,
    S_EMIT_WAIT
  } state_t;

  // Value that a selection pass ranks.
  typedef enum logic [1:0] {
    SRC_U,
    SRC_V,
    SRC_DU,
    SRC_DV
  } src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic first_item;
    logic rd_en;
    src_t src;
    logic sel_init;
    logic sel_second;
    logic decide;
    logic sel_done;
    logic combine;
    logic gate_mul;
    logic gate_set;
    logic emit_load;
    logic emit_last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic m_zero;
    logic m_odd;
    logic out_free;
  } ctrl_sts_t;

endpackage
`default_nettype wire

/* rtl/core/mog_ifs.sv */
// Interfaces: displacement input, result output and gain configuration channels.
`default_nettype none
interface mog_disp_if;
  logic                           valid;
  logic                           ready;
  logic signed [mog_pkg::DISP_W-1:0] disp_u;
  logic signed [mog_pkg::DISP_W-1:0] disp_v;
  logic                           mutual;
  logic                           last_in;
  modport source (output valid, disp_u, disp_v, mutual, last_in, input ready);
  modport sink (input valid, disp_u, disp_v, mutual, last_in, output ready);
endinterface

interface mog_res_if;
  logic                          valid;
  logic                          ready;
  logic [mog_pkg::INDEX_W-1:0]   match_index;
  logic                          inlier;
  logic                          no_mutual;
  logic                          last_out;
  modport source (output valid, match_index, inlier, no_mutual, last_out, input ready);
  modport sink (input valid, match_index, inlier, no_mutual, last_out, output ready);
endinterface

interface mog_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mog_pkg::GAIN_W-1:0]   mad_gain;
  modport source (output valid, mad_gain, input ready);
  modport sink (input valid, mad_gain, output ready);
endinterface
`default_nettype wire

/* rtl/core/mad_outlier_gate.sv */
// Top level: MAD outlier gate over a set of matched displacements.
//
//  Channel | Dir | Payload                                   | Beat accepted when
//  disp    | in  | disp_u, disp_v, mutual, last_in           | valid && ready
//  res     | out | match_index, inlier, no_mutual, last_out  | valid && ready
//  cfg     | in  | mad_gain                                  | valid && ready (always ready)
//
// Beats load while the block is idle. After the last beat of a set of n items with m mutual,
// each median is found by a bitwise rank search: 21 passes, each a scan of the set over the single
// store read port, one search per median for odd m and two for even m, four medians.
// A set without mutual matches skips the searches and goes straight to result output.
// Reset is synchronous: it clears control state and sets the default gain, never the stores.
// A stalled result holds the result register; loading of the next set waits until the last
// result of the set has been loaded into it.
`default_nettype none
module mad_outlier_gate #(
  parameter int MAX_MATCHES = mog_pkg::MAX_MATCHES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  mog_disp_if.sink   disp,
  mog_res_if.source  res,
  mog_cfg_if.sink    cfg
);
  mog_pkg::ctrl_cmd_t cmd;
  mog_pkg::ctrl_sts_t sts;
  logic [$clog2(MAX_MATCHES)-1:0] addr;
  logic [mog_pkg::BIT_W-1:0]      bit_idx;

  // Configuration is always taken.
  assign cfg.ready = 1'b1;

  // Sequencer.
  mog_ctrl #(.MAX_MATCHES(MAX_MATCHES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (disp.valid),
    .in_last  (disp.last_in),
    .in_ready (disp.ready),
    .sts      (sts),
    .cmd      (cmd),
    .addr     (addr),
    .bit_idx  (bit_idx)
  );

  // Store and arithmetic.
  mog_dp #(.MAX_MATCHES(MAX_MATCHES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .addr       (addr),
    .bit_idx    (bit_idx),
    .sts        (sts),
    .in_u       (disp.disp_u),
    .in_v       (disp.disp_v),
    .in_mutual  (disp.mutual),
    .cfg_we     (cfg.valid),
    .cfg_gain   (cfg.mad_gain),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_index  (res.match_index),
    .out_inlier (res.inlier),
    .out_none   (res.no_mutual),
    .out_last   (res.last_out)
  );

endmodule
`default_nettype wire

/* rtl/core/mog_ctrl.sv */
// Controller: sequences loading, rank selections, gate arithmetic and result output.
`default_nettype none
module mog_ctrl #(
  parameter int MAX_MATCHES = mog_pkg::MAX_MATCHES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic                      in_last,
  output logic                           in_ready,
  input  wire mog_pkg::ctrl_sts_t        sts,
  output mog_pkg::ctrl_cmd_t             cmd,
  output logic [$clog2(MAX_MATCHES)-1:0] addr,
  output logic [mog_pkg::BIT_W-1:0]      bit_idx
);
  localparam int AW = $clog2(MAX_MATCHES);
  localparam int CW = $clog2(MAX_MATCHES + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(MAX_MATCHES - 1);

  mog_pkg::state_t state, state_next;
  mog_pkg::src_t   src, src_next;
  logic [CW-1:0]   cnt, cnt_next;
  logic [CW-1:0]   idx, idx_next;
  logic [mog_pkg::BIT_W-1:0] bitn, bitn_next;
  logic            second, second_next;
  logic            in_fire;

  assign in_ready = (state == mog_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign bit_idx  = bitn;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mog_pkg::S_IDLE;
      src    <= mog_pkg::SRC_U;
      cnt    <= '0;
      idx    <= '0;
      bitn   <= '0;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      src    <= src_next;
      cnt    <= cnt_next;
      idx    <= idx_next;
      bitn   <= bitn_next;
      second <= second_next;
    end
  end

  // Next state and counters.
  always_comb begin
    state_next  = state;
    src_next    = src;
    cnt_next    = cnt;
    idx_next    = idx;
    bitn_next   = bitn;
    second_next = second;
    case (state)
      mog_pkg::S_IDLE: begin
        if (in_fire) begin
          cnt_next = cnt + 1'b1;
          if (in_last || cnt == LAST_CNT) state_next = mog_pkg::S_START;
        end
      end
      mog_pkg::S_START: begin
        idx_next = '0;
        if (sts.m_zero) begin
          state_next = mog_pkg::S_EMIT_RD;
        end else begin
          src_next    = mog_pkg::SRC_U;
          second_next = 1'b0;
          bitn_next   = mog_pkg::KEY_TOP_BIT;
          state_next  = mog_pkg::S_SCAN;
        end
      end
      mog_pkg::S_SCAN: begin
        if (idx == cnt) state_next = mog_pkg::S_DECIDE;
        else idx_next = idx + 1'b1;
      end
      mog_pkg::S_DECIDE: begin
        idx_next = '0;
        if (bitn != '0) begin
          bitn_next  = bitn - 1'b1;
          state_next = mog_pkg::S_SCAN;
        end else if (!second && !sts.m_odd) begin
          second_next = 1'b1;
          bitn_next   = mog_pkg::KEY_TOP_BIT;
          state_next  = mog_pkg::S_SCAN;
        end else begin
          state_next = mog_pkg::S_COMBINE;
        end
      end
      mog_pkg::S_COMBINE: begin
        case (src)
          mog_pkg::SRC_U: begin
            src_next    = mog_pkg::SRC_V;
            second_next = 1'b0;
            bitn_next   = mog_pkg::KEY_TOP_BIT;
            state_next  = mog_pkg::S_SCAN;
          end
          mog_pkg::SRC_V: begin
            src_next    = mog_pkg::SRC_DU;
            second_next = 1'b0;
            bitn_next   = mog_pkg::KEY_TOP_BIT;
            state_next  = mog_pkg::S_SCAN;
          end
          default: state_next = mog_pkg::S_GMUL;
        endcase
      end
      mog_pkg::S_GMUL: state_next = mog_pkg::S_GSET;
      mog_pkg::S_GSET: begin
        if (src == mog_pkg::SRC_DU) begin
          src_next    = mog_pkg::SRC_DV;
          second_next = 1'b0;
          bitn_next   = mog_pkg::KEY_TOP_BIT;
          state_next  = mog_pkg::S_SCAN;
        end else begin
          idx_next   = '0;
          state_next = mog_pkg::S_EMIT_RD;
        end
      end
      mog_pkg::S_EMIT_RD: state_next = mog_pkg::S_EMIT_WAIT;
      mog_pkg::S_EMIT_WAIT: begin
        if (sts.out_free) begin
          if (idx == cnt - 1'b1) begin
            cnt_next   = '0;
            state_next = mog_pkg::S_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = mog_pkg::S_EMIT_RD;
          end
        end
      end
      default: state_next = mog_pkg::S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd            = '0;
    cmd.src        = src;
    cmd.first_item = (cnt == '0);
    cmd.sel_second = second;
    addr           = (state == mog_pkg::S_IDLE) ? cnt[AW-1:0] : idx[AW-1:0];
    case (state)
      mog_pkg::S_IDLE:  cmd.load = in_fire;
      mog_pkg::S_START: begin
        cmd.sel_init   = !sts.m_zero;
        cmd.sel_second = 1'b0;
      end
      mog_pkg::S_SCAN:  cmd.rd_en = (idx != cnt);
      mog_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        if (bitn == '0) begin
          cmd.sel_done = 1'b1;
          if (!second && !sts.m_odd) begin
            cmd.sel_init   = 1'b1;
            cmd.sel_second = 1'b1;
          end
        end
      end
      mog_pkg::S_COMBINE: begin
        cmd.combine    = 1'b1;
        cmd.sel_second = 1'b0;
        cmd.sel_init   = (src == mog_pkg::SRC_U) || (src == mog_pkg::SRC_V);
      end
      mog_pkg::S_GMUL: cmd.gate_mul = 1'b1;
      mog_pkg::S_GSET: begin
        cmd.gate_set   = 1'b1;
        cmd.sel_second = 1'b0;
        cmd.sel_init   = (src == mog_pkg::SRC_DU);
      end
      mog_pkg::S_EMIT_RD: cmd.rd_en = 1'b1;
      mog_pkg::S_EMIT_WAIT: begin
        cmd.emit_load = sts.out_free;
        cmd.emit_last = (idx == cnt - 1'b1);
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/mog_dp.sv */
// Datapath: match store, bitwise rank selection, medians, gates and result register.
`default_nettype none
module mog_dp #(
  parameter int MAX_MATCHES = mog_pkg::MAX_MATCHES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire mog_pkg::ctrl_cmd_t                  cmd,
  input  wire logic [$clog2(MAX_MATCHES)-1:0]      addr,
  input  wire logic [mog_pkg::BIT_W-1:0]           bit_idx,
  output mog_pkg::ctrl_sts_t                       sts,
  input  wire logic signed [mog_pkg::DISP_W-1:0]   in_u,
  input  wire logic signed [mog_pkg::DISP_W-1:0]   in_v,
  input  wire logic                                in_mutual,
  input  wire logic                                cfg_we,
  input  wire logic [mog_pkg::GAIN_W-1:0]          cfg_gain,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [mog_pkg::INDEX_W-1:0]              out_index,
  output logic                                     out_inlier,
  output logic                                     out_none,
  output logic                                     out_last
);
  localparam int CW = $clog2(MAX_MATCHES + 1);
  localparam int KW = mog_pkg::KEY_W;
  localparam int DW = mog_pkg::DISP_W;

  // Match store.
  logic [DW-1:0] u_mem [MAX_MATCHES];
  logic [DW-1:0] v_mem [MAX_MATCHES];
  logic          m_mem [MAX_MATCHES];
  logic [DW-1:0] u_rd, v_rd;
  logic          m_rd, rd_valid;

  logic [CW-1:0]  m_cnt, rank, cnt_lt;
  logic [KW-1:0]  pfx, pfx_next, sel_lo, sel_hi;
  logic [DW-1:0]  med_u, med_v;
  logic [KW-1:0]  mad, gate_u, gate_v;
  logic [mog_pkg::GAIN_W-1:0] gain;
  logic [24:0]    gp;
  logic [45:0]    prod;

  logic [KW-1:0]  diff_u, diff_v, dev_u, dev_v, key;
  logic [KW-1:0]  bit_set, hi_mask;
  logic [KW:0]    ge_mask;
  logic           match, take_hi;
  logic [KW-1:0]  msum;
  logic [KW:0]    dsum;
  logic [25:0]    gshift;
  logic [KW-1:0]  gate_val;

  // Store writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u_mem[addr] <= in_u;
      v_mem[addr] <= in_v;
      m_mem[addr] <= in_mutual;
    end
    if (cmd.rd_en) begin
      u_rd <= u_mem[addr];
      v_rd <= v_mem[addr];
      m_rd <= m_mem[addr];
    end
  end

  // Read-valid flag and mutual count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      m_cnt    <= '0;
    end else begin
      rd_valid <= cmd.rd_en;
      if (cmd.load) m_cnt <= (cmd.first_item ? '0 : m_cnt) + CW'(in_mutual);
    end
  end

  assign sts.m_zero   = (m_cnt == '0);
  assign sts.m_odd    = m_cnt[0];
  assign sts.out_free = !out_valid || out_ready;

  // Absolute deviations from the medians.
  always_comb begin
    diff_u = {u_rd[DW-1], u_rd} - {med_u[DW-1], med_u};
    diff_v = {v_rd[DW-1], v_rd} - {med_v[DW-1], med_v};
    dev_u  = diff_u[KW-1] ? -diff_u : diff_u;
    dev_v  = diff_v[KW-1] ? -diff_v : diff_v;
  end

  // Selection key: signed values in offset form, deviations as they are.
  always_comb begin
    case (cmd.src)
      mog_pkg::SRC_U:  key = {1'b0, ~u_rd[DW-1], u_rd[DW-2:0]};
      mog_pkg::SRC_V:  key = {1'b0, ~v_rd[DW-1], v_rd[DW-2:0]};
      mog_pkg::SRC_DU: key = dev_u;
      default:         key = dev_v;
    endcase
  end

  // Prefix match above the current bit and the decision on that bit.
  always_comb begin
    ge_mask  = ((KW+1)'(2) << bit_idx) - (KW+1)'(1);
    hi_mask  = ~ge_mask[KW-1:0];
    bit_set  = KW'(1) << bit_idx;
    match    = (((key ^ pfx) & hi_mask) == '0) && ((key & bit_set) == '0);
    take_hi  = (rank >= cnt_lt);
    pfx_next = take_hi ? (pfx | bit_set) : pfx;
  end

  // Rank search registers. The first search of a median gives the lower value, the
  // second one (even count only) the upper value.
  always_ff @(posedge clk) begin
    if (cmd.sel_init) begin
      pfx    <= '0;
      cnt_lt <= '0;
      rank   <= cmd.sel_second ? (m_cnt >> 1) : ((m_cnt - 1'b1) >> 1);
    end else if (cmd.decide) begin
      pfx    <= pfx_next;
      cnt_lt <= '0;
      if (take_hi) rank <= rank - cnt_lt;
    end else if (rd_valid && m_rd && match) begin
      cnt_lt <= cnt_lt + 1'b1;
    end
    if (cmd.sel_done) begin
      if (cmd.sel_init || !cmd.sel_second) sel_lo <= pfx_next;
      sel_hi <= pfx_next;
    end
  end

  // Floored mean of the two selected keys.
  always_comb begin
    msum = {~sel_lo[DW-1], ~sel_lo[DW-1], sel_lo[DW-2:0]}
         + {~sel_hi[DW-1], ~sel_hi[DW-1], sel_hi[DW-2:0]};
    dsum = {1'b0, sel_lo} + {1'b0, sel_hi};
  end

  // Gate value from the product, saturated and floored at 3 px.
  always_comb begin
    gshift = prod[45:20];
    if (gshift > 26'(mog_pkg::GATE_MAX)) gate_val = mog_pkg::GATE_MAX;
    else if (gshift < 26'(mog_pkg::MIN_GATE_Q8)) gate_val = mog_pkg::MIN_GATE_Q8;
    else gate_val = gshift[KW-1:0];
  end

  // Gain register.
  always_ff @(posedge clk) begin
    if (rst) gain <= mog_pkg::GAIN_RESET;
    else if (cfg_we) gain <= cfg_gain;
  end

  // Medians, MAD and gates.
  always_ff @(posedge clk) begin
    gp <= 25'(gain * mog_pkg::MAD_COEF_Q12);
    if (cmd.combine) begin
      case (cmd.src)
        mog_pkg::SRC_U: med_u <= msum[KW-1:1];
        mog_pkg::SRC_V: med_v <= msum[KW-1:1];
        default:        mad   <= dsum[KW:1];
      endcase
    end
    if (cmd.gate_mul) prod <= gp * mad;
    if (cmd.gate_set) begin
      if (cmd.src == mog_pkg::SRC_DU) gate_u <= gate_val;
      else gate_v <= gate_val;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_index  <= mog_pkg::INDEX_W'(addr);
      out_inlier <= !sts.m_zero && m_rd && (dev_u <= gate_u) && (dev_v <= gate_v);
      out_none   <= sts.m_zero;
      out_last   <= cmd.emit_last;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mog_checker.sv */
// Checker on the top-level ports of the outlier gate, with its bind.
`default_nettype none
`include "assert_macros.svh"
module mog_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          in_last,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [mog_pkg::INDEX_W-1:0]   match_index,
  input wire logic                          inlier,
  input wire logic                          no_mutual,
  input wire logic                          last_out
);
  // A stalled result beat holds its payload.
  `MOG_ASSERT_NXT(a_res_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(match_index) && $stable(inlier) && $stable(no_mutual) && $stable(last_out))

  // The block stops taking beats once the set is closed.
  `MOG_ASSERT_NXT(a_busy_after_last, clk, rst, in_valid && in_ready && in_last, !in_ready)

  // A set without mutual matches has no inliers.
  `MOG_ASSERT_IMP(a_none_no_inlier, clk, rst, out_valid && no_mutual, !inlier)

endmodule

bind mad_outlier_gate mog_checker u_mog_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (disp.valid),
  .in_ready    (disp.ready),
  .in_last     (disp.last_in),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .match_index (res.match_index),
  .inlier      (res.inlier),
  .no_mutual   (res.no_mutual),
  .last_out    (res.last_out)
);
`default_nettype wire

/* tb/mad_outlier_gate_tb.sv */
// Testbench for the MAD outlier gate: directed and random match sets, checked beat by beat.
`timescale 1ns / 100ps
`default_nettype none
module mad_outlier_gate_tb;

  localparam int SET_MAX = 64;
  localparam int PRESSURE_CYCLES = 400;
  localparam int SETTLE_CYCLES = 60;
  localparam int INDEX_W = mog_pkg::INDEX_W;
  localparam int GAIN_W = mog_pkg::GAIN_W;
  localparam int DISP_W = mog_pkg::DISP_W;

  typedef struct packed {
    logic [INDEX_W-1:0] match_index;
    logic               inlier;
    logic               no_mutual;
    logic               last_out;
  } verdict_t;

  logic clk;
  logic rst;

  mog_disp_if disp ();
  mog_res_if  res ();
  mog_cfg_if  cfg ();

  mad_outlier_gate #(.MAX_MATCHES(SET_MAX)) uut (
    .clk  (clk),
    .rst  (rst),
    .disp (disp),
    .res  (res),
    .cfg  (cfg)
  );

  // Model state: gain, the set being loaded and the verdicts still owed.
  logic [GAIN_W-1:0] gain_model;
  longint            set_u [SET_MAX];
  longint            set_v [SET_MAX];
  bit                set_mut [SET_MAX];
  int                set_len;
  verdict_t          verdict_q [$];

  int  err_count;
  int  items_sent;
  int  verdicts_seen;
  int  sets_seen;
  bit  idle_on;
  bit  hold_req;
  bit  hold_done;
  int  hold_left;
  int  rx_gap;

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Median of a list; an even count takes the floored mean of the middle two.
  function automatic longint median_of_list(longint vals [$]);
    longint key;
    int     j;
    int     n;
    n = vals.size();
    for (int i = 1; i < n; i++) begin
      key = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > key) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = key;
    end
    if (n % 2 == 1) return vals[n/2];
    return (vals[n/2-1] + vals[n/2]) >>> 1;
  endfunction

  function automatic longint abs_deviation(longint x, longint centre);
    longint d;
    d = x - centre;
    if (d < 0) d = -d;
    return d & longint'(mog_pkg::GATE_MAX);
  endfunction

  // Gate = gain * 1.4826 * MAD in Q8, saturated and floored at 3 px.
  function automatic longint gate_from_mad(longint mad);
    longint p;
    p = (longint'(gain_model) * longint'(mog_pkg::MAD_COEF_Q12) * mad) >>> 20;
    if (p > longint'(mog_pkg::GATE_MAX)) p = longint'(mog_pkg::GATE_MAX);
    if (p < longint'(mog_pkg::MIN_GATE_Q8)) p = longint'(mog_pkg::MIN_GATE_Q8);
    return p;
  endfunction

  // Evaluate the loaded set and queue one verdict per item.
  task automatic judge_set();
    longint   lst [$];
    longint   med_u, med_v, gate_u, gate_v;
    bit       none;
    verdict_t vd;
    lst = {};
    for (int k = 0; k < set_len; k++) if (set_mut[k]) lst = {lst, set_u[k]};
    none = (lst.size() == 0);
    med_u = 0; med_v = 0; gate_u = 0; gate_v = 0;
    if (!none) begin
      med_u = median_of_list(lst);
      lst = {};
      for (int k = 0; k < set_len; k++) if (set_mut[k]) lst = {lst, set_v[k]};
      med_v = median_of_list(lst);
      lst = {};
      for (int k = 0; k < set_len; k++)
        if (set_mut[k]) lst = {lst, abs_deviation(set_u[k], med_u)};
      gate_u = gate_from_mad(median_of_list(lst));
      lst = {};
      for (int k = 0; k < set_len; k++)
        if (set_mut[k]) lst = {lst, abs_deviation(set_v[k], med_v)};
      gate_v = gate_from_mad(median_of_list(lst));
    end
    for (int k = 0; k < set_len; k++) begin
      vd.match_index = INDEX_W'(k);
      vd.inlier = !none && set_mut[k] && abs_deviation(set_u[k], med_u) <= gate_u &&
                  abs_deviation(set_v[k], med_v) <= gate_v;
      vd.no_mutual = none;
      vd.last_out = (k == set_len - 1);
      verdict_q = {verdict_q, vd};
    end
    set_len = 0;
  endtask

  task automatic report_mismatch(string what);
    err_count++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // Track accepted beats on the input and configuration channels.
  always @(posedge clk) begin
    if (!rst && cfg.valid && cfg.ready) gain_model <= cfg.mad_gain;
    if (!rst && disp.valid && disp.ready) begin
      set_u[set_len] = longint'(disp.disp_u);
      set_v[set_len] = longint'(disp.disp_v);
      set_mut[set_len] = disp.mutual;
      set_len++;
      if (disp.last_in || set_len == SET_MAX) judge_set();
    end
  end

  // Compare every accepted result beat with the oldest verdict.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && res.valid && res.ready) begin
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, index %0d", res.match_index));
      end else begin
        want = verdict_q.pop_front();
        if (res.match_index !== want.match_index)
          report_mismatch($sformatf("index %0d, want %0d", res.match_index, want.match_index));
        if (res.inlier !== want.inlier)
          report_mismatch($sformatf("inlier %b, want %b at index %0d", res.inlier,
                                    want.inlier, want.match_index));
        if (res.no_mutual !== want.no_mutual)
          report_mismatch($sformatf("no_mutual %b, want %b at index %0d", res.no_mutual,
                                    want.no_mutual, want.match_index));
        if (res.last_out !== want.last_out)
          report_mismatch($sformatf("last_out %b, want %b at index %0d", res.last_out,
                                    want.last_out, want.match_index));
        if (want.last_out) sets_seen++;
      end
    end
  end

  // Result receiver: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
      rx_gap <= 0;
    end else if (hold_req && !hold_done) begin
      res.ready <= 1'b0;
      hold_left <= PRESSURE_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      res.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (rx_gap > 0) begin
      res.ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      res.ready <= 1'b0;
      rx_gap <= $urandom_range(0, 9);
    end else begin
      res.ready <= 1'b1;
    end
  end

  // Offer one match; valid stays high afterwards unless the next call idles.
  task automatic send_match(logic signed [DISP_W-1:0] u, logic signed [DISP_W-1:0] v,
                            bit mut, bit last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      disp.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    disp.valid <= 1'b1;
    disp.disp_u <= u;
    disp.disp_v <= v;
    disp.mutual <= mut;
    disp.last_in <= last;
    @(posedge clk);
    while (!disp.ready) @(posedge clk);
    items_sent++;
  endtask

  // Wait until every owed verdict has come and the block has settled.
  task automatic drain();
    disp.valid <= 1'b0;
    while (verdict_q.size() != 0 || set_len != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(logic [GAIN_W-1:0] g);
    cfg.valid <= 1'b1;
    cfg.mad_gain <= g;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // A set of n matches clustered round a centre, with some outliers and non-mutual ones.
  task automatic send_cluster(int n, int spread, int outlier_pct, int mutual_pct);
    int c_u, c_v, u, v;
    c_u = $urandom_range(0, 200000) - 100000;
    c_v = $urandom_range(0, 200000) - 100000;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < outlier_pct) begin
        u = int'($urandom) % 524288;
        v = int'($urandom) % 524288;
      end else begin
        u = c_u + $urandom_range(0, 2 * spread) - spread;
        v = c_v + $urandom_range(0, 2 * spread) - spread;
      end
      send_match(DISP_W'(u), DISP_W'(v), $urandom_range(0, 99) < mutual_pct, k == n - 1);
    end
  endtask

  // Extremes of the fields, single items, no mutual match, odd and even counts.
  task automatic test_directed();
    send_match(20'sh80000, 20'sh7FFFF, 1'b1, 1'b1);
    send_match(20'sh7FFFF, 20'sh80000, 1'b0, 1'b0);
    send_match(20'sh00000, 20'sh00000, 1'b0, 1'b1);
    // Even count across the full range: the middle pair averages with floor.
    send_match(20'sh7FFFF, 20'sh80000, 1'b1, 1'b0);
    send_match(20'sh80000, 20'sh7FFFF, 1'b1, 1'b1);
    // Odd item count, even mutual count, with one far outlier and one non-mutual match.
    send_match(20'sd256, 20'sd512, 1'b1, 1'b0);
    send_match(20'sd300, 20'sd500, 1'b1, 1'b0);
    send_match(20'sd260, 20'sd520, 1'b1, 1'b0);
    send_match(20'sd100000, -20'sd90000, 1'b1, 1'b0);
    send_match(20'sd270, 20'sd510, 1'b0, 1'b1);
    // Mostly equal v values: a MAD of zero leaves the v gate at only the 3 px floor.
    send_match(-20'sd1000, -20'sd1000, 1'b1, 1'b0);
    send_match(-20'sd1000, -20'sd1000, 1'b1, 1'b0);
    send_match(-20'sd233, -20'sd1767, 1'b1, 1'b0);
    send_match(-20'sd231, -20'sd1000, 1'b1, 1'b1);
    drain();
  endtask

  // Gain at both extremes; zero gain leaves only the floor of the gate.
  task automatic test_gain_extremes();
    write_gain('0);
    send_cluster(7, 4000, 20, 90);
    drain();
    write_gain({GAIN_W{1'b1}});
    send_cluster(7, 4000, 20, 90);
    send_cluster(6, 200000, 30, 90);
    drain();
  endtask

  // A set that fills the store without a last flag closes itself.
  task automatic test_store_full();
    write_gain(GAIN_W'(512));
    for (int k = 0; k < SET_MAX; k++)
      send_match(DISP_W'($urandom_range(0, 3000)), DISP_W'($urandom_range(0, 3000)),
                 $urandom_range(0, 7) != 0, 1'b0);
    drain();
  endtask

  // The receiver holds off while sets keep coming, so the input must stall.
  task automatic test_backpressure();
    @(negedge clk);
    hold_req = 1'b1;
    send_cluster(20, 2000, 10, 85);
    send_cluster(8, 2000, 10, 85);
    drain();
  endtask

  // Random sets, mostly well formed, some pure noise, at changing gains.
  task automatic test_random(int goal);
    int n;
    while (items_sent < goal) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 10);
      if ($urandom_range(0, 5) == 0) send_cluster(n, 262143, 100, 50);
      else send_cluster(n, $urandom_range(1, 8000), $urandom_range(0, 25), 85);
      if ($urandom_range(0, 5) == 0) begin
        drain();
        write_gain(GAIN_W'($urandom_range(0, 4095)));
      end
    end
    drain();
  endtask

  // Test sequence.
  initial begin
    rst = 1'b1;
    idle_on = 1'b1;
    hold_req = 1'b0;
    err_count = 0;
    items_sent = 0;
    verdicts_seen = 0;
    sets_seen = 0;
    set_len = 0;
    gain_model = mog_pkg::GAIN_RESET;
    disp.valid = 1'b0;
    disp.disp_u = '0;
    disp.disp_v = '0;
    disp.mutual = 1'b0;
    disp.last_in = 1'b0;
    cfg.valid = 1'b0;
    cfg.mad_gain = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_gain_extremes();
    test_store_full();
    test_backpressure();
    test_random(items_sent + 15);
    @(negedge clk);
    idle_on = 1'b0;
    write_gain(mog_pkg::GAIN_RESET);
    test_random(items_sent + 10);
    $display("Covered %0d matches in %0d sets, %0d result beats checked,", items_sent,
             sets_seen, verdicts_seen);
    $display("including gain extremes, a full store, no-mutual sets and a long stall.");
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("Timed out with %0d results outstanding.", verdict_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/mog_pkg.sv
rtl/core/mog_ifs.sv
rtl/core/mog_ctrl.sv
rtl/core/mog_dp.sv
rtl/core/mad_outlier_gate.sv
rtl/core/mog_checker.sv
tb/mad_outlier_gate_tb.sv
